// ===== rtl/ufbs_pkg.sv =====
package ufbs_pkg;

	// Field widths
	localparam int CLK_W  = 28;
	localparam int PCT_W  = 7;
	localparam int BAUD_W = 24;
	localparam int DL_W   = 16;
	localparam int MUL_W  = 4;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// Shared divider: dividend width and step counter width
	localparam int NUM_W  = 32;
	localparam int STEP_W = 5;

	// Divider iterations per division, two radix-2 steps each (two bits retired per cycle)
	localparam logic [STEP_W-1:0] STEPS_T    = 5'd14;  // 28-bit scaled base clock
	localparam logic [STEP_W-1:0] STEPS_BAUD = 5'd12;  // 24-bit intermediate clock
	localparam logic [STEP_W-1:0] STEPS_LIM  = 5'd16;  // 31-bit error limit product

	// Search and range constants
	localparam logic [MUL_W-1:0] DIVADD_LAST = 4'd15;
	localparam int unsigned      DIV_MIN     = 3;
	localparam int unsigned      DIV_MAX     = 65535;
	localparam int unsigned      PCT_SCALE   = 100;

	// Register reset values
	localparam logic [CLK_W-1:0] CLK_RESET = 28'd25000000;
	localparam logic [PCT_W-1:0] PCT_RESET = 7'd3;

	// Register map, index = paddr[2]
	typedef enum logic {
		REG_CLK = 1'b0,
		REG_PCT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CLK_W-1:0] uart_clock_hz;
		logic [PCT_W-1:0] accepted_error_percent;
	} cfg_t;

	typedef struct packed {
		logic [BAUD_W-1:0] requested_baud;
	} req_t;

	typedef struct packed {
		logic [DL_W-1:0]  divisor_latch;
		logic [MUL_W-1:0] mul_value;
		logic [MUL_W-1:0] div_add_value;
		logic             setting_ok;
	} rsp_t;

	// Divider command from the sequencer
	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  dividend;   // left-aligned on the steps used
		logic [BAUD_W-1:0] divisor;
		logic [STEP_W-1:0] steps;
	} div_cmd_t;

	// Divider result back to the sequencer
	typedef struct packed {
		logic              done;
		logic [NUM_W-1:0]  quotient;
		logic [BAUD_W-1:0] remainder;
	} div_res_t;

endpackage

// ===== rtl/ufbs_req_if.sv =====
interface ufbs_req_if import ufbs_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/ufbs_rsp_if.sv =====
interface ufbs_rsp_if import ufbs_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/ufbs_div.sv =====
// Shared restoring divider, two quotient bits per cycle
module ufbs_div import ufbs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_cmd_t cmd,
	output div_res_t res
);

	typedef struct packed {
		logic [BAUD_W-1:0] rem;
		logic [NUM_W-1:0]  num;
	} step_t;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	function automatic step_t div_step(step_t s, logic [BAUD_W-1:0] d);
		logic [BAUD_W:0] trial;
		step_t r;
		trial = {s.rem, s.num[NUM_W-1]};
		r.num = {s.num[NUM_W-2:0], 1'b0};
		r.rem = trial[BAUD_W-1:0];
		if (trial >= {1'b0, d}) begin
			r.rem = BAUD_W'(trial - {1'b0, d});
			r.num[0] = 1'b1;
		end
		return r;
	endfunction

	logic [NUM_W-1:0]  num_q;
	logic [BAUD_W-1:0] rem_q;
	logic [BAUD_W-1:0] dvs_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	step_t             st0, st1, st2;

	// Two chained steps per cycle
	always_comb begin
		st0 = '{rem: rem_q, num: num_q};
		st1 = div_step(st0, dvs_q);
		st2 = div_step(st1, dvs_q);
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			num_q <= cmd.dividend;
			rem_q <= '0;
			dvs_q <= cmd.divisor;
		end else if (busy_q) begin
			num_q <= st2.num;
			rem_q <= st2.rem;
		end
	end

	assign res.done      = done_q;
	assign res.quotient  = num_q;
	assign res.remainder = rem_q;

endmodule

// ===== rtl/ufbs_cfg.sv =====
// APB register block: UART clock and accepted error
module ufbs_cfg import ufbs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.uart_clock_hz          <= CLK_RESET;
			cfg_q.accepted_error_percent <= PCT_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_CLK: cfg_q.uart_clock_hz          <= pwdata[CLK_W-1:0];
				REG_PCT: cfg_q.accepted_error_percent <= pwdata[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			REG_CLK: prdata = {{(DATA_W-CLK_W){1'b0}}, cfg_q.uart_clock_hz};
			REG_PCT: prdata = {{(DATA_W-PCT_W){1'b0}}, cfg_q.accepted_error_percent};
			default: prdata = '0;
		endcase
	end

endmodule

// ===== rtl/ufbs_seq.sv =====
// Search sequencer: walks MUL/DIVADD pairs, drives the shared divider
module ufbs_seq import ufbs_pkg::*; #(
	parameter int MAX_MUL = 15
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	ufbs_req_if.sink   req,
	ufbs_rsp_if.source rsp,
	output div_cmd_t cmd,
	input  div_res_t res
);

	localparam logic [MUL_W-1:0] MUL_LAST = MUL_W'(MAX_MUL);

	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_T_ISSUE   = 8'b0000_0010,
		S_T_DIV     = 8'b0000_0100,
		S_D_DIV     = 8'b0000_1000,
		S_A_DIV     = 8'b0001_0000,
		S_LIM_ISSUE = 8'b0010_0000,
		S_LIM_DIV   = 8'b0100_0000,
		S_OUT       = 8'b1000_0000
	} seq_state_t;

	seq_state_t        state_q;
	logic [BAUD_W-1:0] baud_q;
	logic [MUL_W-1:0]  mul_q, add_q;
	logic [BAUD_W-1:0] t_q;
	logic              found_q;
	logic [BAUD_W-1:0] best_err_q;
	logic [DL_W-1:0]   best_d_q;
	logic [MUL_W-1:0]  best_mul_q, best_add_q;
	logic              ok_q;
	logic [DL_W-1:0]   cmd_d_hold_q;

	logic [BAUD_W-1:0] base;
	logic [CLK_W-1:0]  prod_t;
	logic [MUL_W:0]    mul_add;
	logic              round_up;
	logic [BAUD_W:0]   d_full;
	logic              d_ok;
	logic [BAUD_W-1:0] a_val, err;
	logic              better;
	logic [30:0]       lim_prod;
	logic              last_pair;
	logic [MUL_W-1:0]  mul_nxt, add_nxt;

	// Candidate arithmetic around the divider
	always_comb begin
		base     = cfg.uart_clock_hz[CLK_W-1:4];
		prod_t   = {{(CLK_W-MUL_W){1'b0}}, mul_q} * {{(CLK_W-BAUD_W){1'b0}}, base};
		mul_add  = {1'b0, mul_q} + {1'b0, add_q};
		round_up = res.remainder > {1'b0, baud_q[BAUD_W-1:1]};
		d_full   = {1'b0, res.quotient[BAUD_W-1:0]} + {{BAUD_W{1'b0}}, round_up};
		d_ok     = (d_full >= (BAUD_W+1)'(DIV_MIN)) && (d_full <= (BAUD_W+1)'(DIV_MAX));
		a_val    = res.quotient[BAUD_W-1:0];
		err      = (a_val <= baud_q) ? (baud_q - a_val) : (a_val - baud_q);
		better   = !found_q || (err < best_err_q);
		lim_prod = {7'd0, baud_q} * {24'd0, cfg.accepted_error_percent};
	end

	// Next pair in search order
	always_comb begin
		last_pair = (mul_q == MUL_LAST) && (add_q == DIVADD_LAST);
		if (add_q == DIVADD_LAST) begin
			add_nxt = '0;
			mul_nxt = mul_q + 1'b1;
		end else begin
			add_nxt = add_q + 1'b1;
			mul_nxt = mul_q;
		end
	end

	// Divider requests
	always_comb begin
		cmd = '0;
		case (state_q)
			S_T_ISSUE: begin
				cmd.start    = 1'b1;
				cmd.dividend = {prod_t, 4'd0};
				cmd.divisor  = {{(BAUD_W-MUL_W-1){1'b0}}, mul_add};
				cmd.steps    = STEPS_T;
			end
			S_T_DIV: begin
				cmd.start    = res.done;
				cmd.dividend = {res.quotient[BAUD_W-1:0], 8'd0};
				cmd.divisor  = baud_q;
				cmd.steps    = STEPS_BAUD;
			end
			S_D_DIV: begin
				cmd.start    = res.done && d_ok;
				cmd.dividend = {t_q, 8'd0};
				cmd.divisor  = {8'd0, d_full[DL_W-1:0]};
				cmd.steps    = STEPS_BAUD;
			end
			S_LIM_ISSUE: begin
				cmd.start    = found_q;
				cmd.dividend = {1'b0, lim_prod};
				cmd.divisor  = BAUD_W'(PCT_SCALE);
				cmd.steps    = STEPS_LIM;
			end
			default: cmd = '0;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			baud_q     <= '0;
			mul_q      <= '0;
			add_q      <= '0;
			t_q        <= '0;
			found_q    <= 1'b0;
			best_err_q <= '0;
			best_d_q   <= '0;
			best_mul_q <= '0;
			best_add_q <= '0;
			ok_q       <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						baud_q     <= req.data.requested_baud;
						mul_q      <= MUL_W'(1);
						add_q      <= '0;
						found_q    <= 1'b0;
						best_d_q   <= '0;
						best_mul_q <= MUL_W'(1);
						best_add_q <= '0;
						ok_q       <= 1'b0;
						state_q    <= (req.data.requested_baud == '0) ? S_OUT : S_T_ISSUE;
					end
				end
				S_T_ISSUE: state_q <= S_T_DIV;
				S_T_DIV: begin
					if (res.done) begin
						t_q     <= res.quotient[BAUD_W-1:0];
						state_q <= S_D_DIV;
					end
				end
				S_D_DIV: begin
					if (res.done) begin
						if (d_ok) begin
							state_q <= S_A_DIV;
						end else if (last_pair) begin
							state_q <= S_LIM_ISSUE;
						end else begin
							mul_q   <= mul_nxt;
							add_q   <= add_nxt;
							state_q <= S_T_ISSUE;
						end
					end
				end
				S_A_DIV: begin
					if (res.done) begin
						// divisor register of the divider still holds D
						if (better) begin
							found_q    <= 1'b1;
							best_err_q <= err;
							best_d_q   <= cmd_d_hold_q;
							best_mul_q <= mul_q;
							best_add_q <= add_q;
						end
						if ((better && err == '0) || last_pair) begin
							state_q <= S_LIM_ISSUE;
						end else begin
							mul_q   <= mul_nxt;
							add_q   <= add_nxt;
							state_q <= S_T_ISSUE;
						end
					end
				end
				S_LIM_ISSUE: state_q <= found_q ? S_LIM_DIV : S_OUT;
				S_LIM_DIV: begin
					if (res.done) begin
						ok_q    <= {1'b0, best_err_q} < res.quotient[BAUD_W:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (rsp.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Candidate divider kept while the achieved rate is worked out
	always_ff @(posedge clk) begin
		if (state_q == S_D_DIV && res.done && d_ok)
			cmd_d_hold_q <= d_full[DL_W-1:0];
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = (state_q == S_OUT);
	assign rsp.data  = '{divisor_latch: best_d_q, mul_value: best_mul_q,
		div_add_value: best_add_q, setting_ok: ok_q};

endmodule

// ===== rtl/uart_fractional_baud_search.sv =====
// Fractional baud-rate divider search. Each request carries a baud rate; the
// block tries every multiplier 1..MAX_MUL with every divide-add 0..15 against
// the base clock uart_clock_hz/16, keeps the first pair with the smallest
// absolute baud error among dividers 3..65535, and returns the divider, the
// pair and an ok flag (error below accepted_error_percent of the rate).
// All divisions share one radix-2 divider retiring two bits a cycle. A
// candidate pair costs three divisions (scaled base clock, divider, achieved
// rate), and a pair whose divider falls out of range only the first two. A
// full search covers at most MAX_MUL x 16 pairs, an exact match ends it early,
// a final division checks the limit when a pair was found, and a zero request
// is answered without a search. One request is in flight at a time: the
// request side is ready only when the previous response has been taken.
module uart_fractional_baud_search import ufbs_pkg::*; #(
	parameter int MAX_MUL = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	ufbs_req_if.sink          req,
	ufbs_rsp_if.source        rsp
);

	cfg_t     cfg;
	div_cmd_t div_cmd;
	div_res_t div_res;

	// Configuration registers
	ufbs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Search control
	ufbs_seq #(
		.MAX_MUL (MAX_MUL)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp),
		.cmd    (div_cmd),
		.res    (div_res)
	);

	// Shared divider
	ufbs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.res    (div_res)
	);

endmodule

// ===== rtl/ufbs_chk.sv =====
// Port-level checks for the baud search block
module ufbs_chk import ufbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);

	// No new request is taken while a response is pending
	a_busy_on_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request side ready while a response is pending");

	// A search occupies the block for at least the cycle after acceptance
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request side still ready right after acceptance");

	// A stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
		else $error("stalled response changed or dropped");

	// An accepted setting always carries a usable divider and multiplier
	a_ok_sane: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.setting_ok) |->
			(rsp_data.divisor_latch >= DL_W'(DIV_MIN) && rsp_data.mul_value != '0))
		else $error("setting flagged ok with an unusable divider");

endmodule

bind uart_fractional_baud_search ufbs_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
